@@ rtl/core/cat_pkg.sv @@
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and constants for the comment-aware tokenizer core.
// ----------------------------------------------------------------------------
package cat_pkg;

  // token length counter and limit width
  localparam int unsigned LenW = 12;
  localparam logic [LenW-1:0] MaxLenReset = 12'd255;

  // character codes
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;

  // scanner state
  typedef enum logic [1:0] {
    MODE_SKIP    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_TOKEN   = 2'd2,
    MODE_QUOTED  = 2'd3
  } scan_mode_e;

  // one scan result
  typedef struct packed {
    logic       char_valid;
    logic [7:0] out_char;
    logic       token_end;
    logic       truncated;
    logic       input_done;
  } scan_res_t;

endpackage

@@ rtl/core/cat_scan.sv @@
// ----------------------------------------------------------------------------
// cat_scan
// Scanner state and per-character decode; advances one character per step.
// ----------------------------------------------------------------------------
module cat_scan import cat_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      char_i,
  input  logic            end_i,
  input  logic [LenW-1:0] max_len_i,
  output scan_res_t       res_o
);

  scan_mode_e      mode_q, mode_d;
  logic [LenW-1:0] count_q, count_d;

  logic            is_sep;
  logic            emit;
  logic            end_tok;
  logic            done;
  logic [LenW-1:0] cnt_inc;
  logic            hit;

  // character class and length limit check
  assign is_sep  = (char_i == ChSpace) || (char_i == ChTab) || (char_i == ChNl);
  assign cnt_inc = ((mode_q == MODE_SKIP) ? '0 : count_q) + LenW'(1);
  assign hit     = (cnt_inc >= max_len_i);

  // decode what this character does
  always_comb begin
    emit    = 1'b0;
    end_tok = 1'b0;
    done    = 1'b0;
    if (end_i) begin
      if ((mode_q == MODE_TOKEN) || (mode_q == MODE_QUOTED)) begin
        end_tok = 1'b1;
      end else begin
        done = 1'b1;
      end
    end else begin
      unique case (mode_q)
        MODE_SKIP: begin
          emit = !is_sep && (char_i != ChHash) && (char_i != ChQuote);
        end
        MODE_COMMENT: begin
        end
        MODE_TOKEN: begin
          end_tok = is_sep;
          emit    = !is_sep && (char_i != ChQuote);
        end
        MODE_QUOTED: begin
          end_tok = (char_i == ChQuote);
          emit    = (char_i != ChQuote);
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    if (end_i) begin
      mode_d  = MODE_SKIP;
      count_d = '0;
    end else begin
      unique case (mode_q)
        MODE_SKIP: begin
          if (char_i == ChHash) begin
            mode_d = MODE_COMMENT;
          end else if (char_i == ChQuote) begin
            mode_d  = MODE_QUOTED;
            count_d = '0;
          end else if (!is_sep) begin
            mode_d = MODE_TOKEN;
          end
        end
        MODE_COMMENT: begin
          if (char_i == ChNl) begin
            mode_d = MODE_SKIP;
          end
        end
        MODE_TOKEN: begin
          if (char_i == ChQuote) begin
            mode_d = MODE_QUOTED;
          end
        end
        MODE_QUOTED: begin
        end
        default: begin
        end
      endcase
      if (emit) begin
        count_d = cnt_inc;
      end
      if (end_tok || (emit && hit)) begin
        mode_d  = MODE_SKIP;
        count_d = '0;
      end
    end
  end

  // result fields
  always_comb begin
    res_o.char_valid = emit;
    res_o.out_char   = emit ? char_i : 8'h00;
    res_o.token_end  = end_tok || (emit && hit);
    res_o.truncated  = emit && hit;
    res_o.input_done = done;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SKIP;
      count_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

endmodule

@@ rtl/core/comment_aware_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// comment_aware_tokenizer_core
// Whitespace tokenizer with quoted parts and line comments, one byte a beat.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input beat passes the input register, then the result register,
// which holds while its result is not taken and so stalls the beat behind it.
// Throughput: one beat per cycle without a stall; the scanner state update is one step.
// Reset: scanner returns to whitespace skipping, count zero, limit 255,
// both pipeline stages empty.
module comment_aware_tokenizer_core import cat_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input stream
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] in_char
  input  logic            s_axis_tlast,   // in_end
  // result stream
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_char
  output logic            m_axis_tlast,   // token_end
  output logic [2:0]      m_axis_tuser,   // [0] char_valid [1] truncated [2] input_done
  // configuration
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i
);

  logic            s1_valid_q, s1_valid_d;
  logic [7:0]      s1_char_q;
  logic            s1_end_q;
  logic            out_valid_q, out_valid_d;
  scan_res_t       out_q;
  scan_res_t       res;
  logic [LenW-1:0] max_len_q;
  logic            in_acc;
  logic            out_adv;
  logic            step;

  // pipeline handshake
  assign out_adv       = !out_valid_q || m_axis_tready;
  assign step          = s1_valid_q && out_adv;
  assign s_axis_tready = !s1_valid_q || out_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_adv ? s1_valid_q : out_valid_q;
  end

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q <= s_axis_tdata;
      s1_end_q  <= s_axis_tlast;
    end
  end

  // scanner
  cat_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .char_i    (s1_char_q),
    .end_i     (s1_end_q),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.out_char;
  assign m_axis_tlast  = out_q.token_end;
  assign m_axis_tuser  = {out_q.input_done, out_q.truncated, out_q.char_valid};

  // checks
  a_trunc_ends_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.truncated |-> out_q.token_end && out_q.char_valid)
    else $error("truncation without token end");

  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.input_done |-> !out_q.token_end && !out_q.char_valid)
    else $error("input done together with token data");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.char_valid |-> out_q.out_char == 8'h00)
    else $error("stray character without char_valid");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while result side flows");

endmodule
